/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker modules
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Expression must never be true at a rising clock edge outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
   `ASSERT_CLK(label, clk, rst, !(expr))

`endif

/* src/dro_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dro_pkg
// Types and constants of the display reorder buffer.
// ---------------------------------------------------------------------------
package dro_pkg;

   // Default configuration
   localparam int DRO_SLOTS    = 4;
   localparam int DRO_TAG_BITS = 16;

   // Fixed field widths of the request and result
   localparam int ORDER_W = 32;
   localparam int TAG_W   = 16;

   // Request codes
   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_FLUSH  = 1'b1
   } dro_op_type;

   // Request as held in the input register
   typedef struct packed {
      logic               req_type;
      logic [ORDER_W-1:0] pic_order;
      logic [TAG_W-1:0]   frame_tag;
   } dro_req_type;

   // Result as produced by the slot store
   typedef struct packed {
      logic               emitted;
      logic [TAG_W-1:0]   out_tag;
      logic [ORDER_W-1:0] out_order;
      logic               error;
   } dro_rsp_type;

endpackage

/* src/dro_req_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dro_req_if
// Request channel: valid/ready handshake carrying insert and flush requests.
// ---------------------------------------------------------------------------
interface dro_req_if import dro_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [ORDER_W-1:0] pic_order;
   logic [TAG_W-1:0]   frame_tag;

   modport source (output valid, req_type, pic_order, frame_tag, input ready);
   modport sink   (input valid, req_type, pic_order, frame_tag, output ready);
   modport monitor (input valid, ready, req_type, pic_order, frame_tag);
endinterface

/* src/dro_rsp_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dro_rsp_if
// Result channel: valid/ready handshake carrying one result per request.
// ---------------------------------------------------------------------------
interface dro_rsp_if import dro_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               emitted;
   logic [TAG_W-1:0]   out_tag;
   logic [ORDER_W-1:0] out_order;
   logic               error;

   modport source (output valid, emitted, out_tag, out_order, error, input ready);
   modport sink   (input valid, emitted, out_tag, out_order, error, output ready);
   modport monitor (input valid, ready, emitted, out_tag, out_order, error);
endinterface

/* src/dro_slots.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dro_slots
// Slot store with combinational free-slot search and match; insert and release are registered on each fired request.
// ---------------------------------------------------------------------------
module dro_slots import dro_pkg::*; #(
   parameter int SLOTS    = DRO_SLOTS,
   parameter int TAG_BITS = DRO_TAG_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        fire,
   input  dro_req_type req,
   output dro_rsp_type rsp
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam logic [TAG_W-1:0] TAG_MASK =
      (TAG_BITS >= TAG_W) ? {TAG_W{1'b1}} : TAG_W'((64'd1 << TAG_BITS) - 64'd1);

   logic [SLOTS-1:0]   valid_ff, valid_in;
   logic [ORDER_W-1:0] order_ff [SLOTS];
   logic [TAG_W-1:0]   tag_ff   [SLOTS];
   logic [ORDER_W-1:0] expected_ff, expected_in;

   logic               full;
   logic               refuse;
   logic               do_ins;
   logic [IDX_W-1:0]   free_idx;
   logic [SLOTS-1:0]   ins_sel;
   logic [SLOTS-1:0]   hit;
   logic               hit_any;
   logic [IDX_W-1:0]   hit_idx;
   logic               emit;
   logic [SLOTS-1:0]   release_vec;
   logic [TAG_W-1:0]   tag_masked;
   logic [TAG_W-1:0]   hit_tag;

   // Pick the lowest-indexed free slot.
   always_comb begin
      free_idx = '0;
      for (int s = SLOTS - 1; s >= 0; s--) begin
         if (!valid_ff[s]) begin
            free_idx = IDX_W'(s);
         end
      end
   end

   assign full       = &valid_ff;
   assign refuse     = (req.req_type == REQ_INSERT) && full;
   assign do_ins     = (req.req_type == REQ_INSERT) && !full;
   assign tag_masked = req.frame_tag & TAG_MASK;

   // Match against stored slots, bypassing the slot being written now
   always_comb begin
      for (int s = 0; s < SLOTS; s++) begin
         ins_sel[s] = do_ins && (free_idx == IDX_W'(s));
         hit[s] = ins_sel[s] ? (req.pic_order == expected_ff)
                             : (valid_ff[s] && (order_ff[s] == expected_ff));
      end
   end

   // Pick the lowest-indexed match
   always_comb begin
      hit_idx = '0;
      for (int s = SLOTS - 1; s >= 0; s--) begin
         if (hit[s]) begin
            hit_idx = IDX_W'(s);
         end
      end
   end

   assign hit_any = |hit;
   assign emit    = hit_any && !refuse;
   assign hit_tag = ins_sel[hit_idx] ? tag_masked : tag_ff[hit_idx];

   always_comb begin
      release_vec = '0;
      if (emit) begin
         release_vec[hit_idx] = 1'b1;
      end
   end

   // Result of the current request
   always_comb begin
      rsp.emitted   = emit;
      rsp.out_tag   = emit ? hit_tag : '0;
      rsp.out_order = emit ? expected_ff : '0;
      rsp.error     = refuse;
   end

   // Next state
   always_comb begin
      valid_in    = (valid_ff | ins_sel) & ~release_vec;
      expected_in = emit ? expected_ff + ORDER_W'(1) : expected_ff;
   end

   // Hold control state, advance on each request
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         expected_ff <= '0;
      end else if (fire) begin
         valid_ff    <= valid_in;
         expected_ff <= expected_in;
      end
   end

   // Write the inserted frame into its slot
   always_ff @(posedge clock) begin
      for (int s = 0; s < SLOTS; s++) begin
         if (fire && ins_sel[s]) begin
            order_ff[s] <= req.pic_order;
            tag_ff[s]   <= tag_masked;
         end
      end
   end

endmodule

/* src/display_reorder_buffer.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// display_reorder_buffer
// Reorders decoded frame handles from decode order into display order.
// ---------------------------------------------------------------------------
// One request is taken every clock cycle while the result register is not
// stalled; its result passes through the input register, then the result
// register, before it is presented on the result port. The free-slot
// search, the order match over all SLOTS slots and the slot update are all
// done between those two registers. An insert goes into the lowest free
// slot; if every slot is full the result flags error and nothing changes.
// After an insert, or on a flush, the lowest-indexed slot holding the
// expected display order, if any, is released and the expected order
// advances (wrapping at 32 bits). A stalled result register holds the
// request behind it. Reset empties the buffer at once.
// ---------------------------------------------------------------------------
module display_reorder_buffer import dro_pkg::*; #(
   parameter int SLOTS    = DRO_SLOTS,
   parameter int TAG_BITS = DRO_TAG_BITS
) (
   input logic      clock,
   input logic      reset,
   dro_req_if.sink  req_port,
   dro_rsp_if.source rsp_port
);

   logic        in_valid_ff, in_valid_in;
   dro_req_type in_req_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   dro_rsp_type rsp_ff;
   dro_rsp_type slot_rsp;
   logic        advance;
   logic        fire;

   // Move the held request on when the result register is free or drains
   assign advance        = !rsp_valid_ff || rsp_port.ready;
   assign fire           = in_valid_ff && advance;
   assign req_port.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = req_port.ready ? req_port.valid : in_valid_ff;
      rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_port.ready && req_port.valid) begin
         in_req_ff.req_type  <= req_port.req_type;
         in_req_ff.pic_order <= req_port.pic_order;
         in_req_ff.frame_tag <= req_port.frame_tag;
      end
   end

   dro_slots #(
      .SLOTS   (SLOTS),
      .TAG_BITS(TAG_BITS)
   ) u_slots (
      .clock(clock),
      .reset(reset),
      .fire (fire),
      .req  (in_req_ff),
      .rsp  (slot_rsp)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= slot_rsp;
      end
   end

   assign rsp_port.valid     = rsp_valid_ff;
   assign rsp_port.emitted   = rsp_ff.emitted;
   assign rsp_port.out_tag   = rsp_ff.out_tag;
   assign rsp_port.out_order = rsp_ff.out_order;
   assign rsp_port.error     = rsp_ff.error;

endmodule

/* src/dro_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dro_checker
// Port-level checks of the display reorder buffer, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dro_checker import dro_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_emitted,
   input logic [TAG_W-1:0]   rsp_out_tag,
   input logic [ORDER_W-1:0] rsp_out_order,
   input logic               rsp_error
);

   logic                         req_acc;
   logic                         rsp_acc;
   logic                         rsp_stall;
   logic                         rsp_released;
   logic                         rsp_refused;
   logic [TAG_W+ORDER_W:0]       rsp_release_bits;
   logic [TAG_W+ORDER_W+1:0]     rsp_payload;
   logic [1:0]                   pend_ff, pend_in;
   logic [ORDER_W-1:0]           next_order_ff, next_order_in;

   assign req_acc          = req_valid && req_ready;
   assign rsp_acc          = rsp_valid && rsp_ready;
   assign rsp_stall        = rsp_valid && !rsp_ready;
   assign rsp_released     = rsp_valid && rsp_emitted;
   assign rsp_refused      = rsp_valid && rsp_error;
   assign rsp_release_bits = {rsp_emitted, rsp_out_tag, rsp_out_order};
   assign rsp_payload      = {rsp_release_bits, rsp_error};

   // Track requests in flight and the next display order to be released
   always_comb begin
      pend_in       = pend_ff + 2'(req_acc) - 2'(rsp_acc);
      next_order_in = (rsp_acc && rsp_emitted) ? next_order_ff + ORDER_W'(1)
                                               : next_order_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff       <= '0;
         next_order_ff <= '0;
      end else begin
         pend_ff       <= pend_in;
         next_order_ff <= next_order_in;
      end
   end

   // A stalled result holds
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_stall |=> (rsp_valid && $stable(rsp_payload)))

   // Every result answers an accepted request
   `ASSERT_NEVER(a_no_orphan, clock, reset, rsp_valid && (pend_ff == 2'd0))

   // Frames leave in consecutive display order
   `ASSERT_CLK(a_order_seq, clock, reset, rsp_released |-> (rsp_out_order == next_order_ff))

   // A refused insert releases nothing
   `ASSERT_CLK(a_error_quiet, clock, reset, rsp_refused |-> (rsp_release_bits == '0))

endmodule

bind display_reorder_buffer dro_checker u_dro_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_port.valid),
   .req_ready    (req_port.ready),
   .rsp_valid    (rsp_port.valid),
   .rsp_ready    (rsp_port.ready),
   .rsp_emitted  (rsp_port.emitted),
   .rsp_out_tag  (rsp_port.out_tag),
   .rsp_out_order(rsp_port.out_order),
   .rsp_error    (rsp_port.error)
);
